@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL of the digit trie conflict checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DTPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtpc assertion failed");

`else

`define DTPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/dtpc_pkg.sv @@
// Shared constants and types of the digit trie conflict checker.
package dtpc_pkg;

    // Size of the node pool and number of child links per node.
    localparam int unsigned NODE_COUNT = 65536;
    localparam int unsigned RADIX      = 10;

    // Field and storage widths.
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned DIGIT_EXT_W = DIGIT_W + 1;
    localparam int unsigned NODE_W      = $clog2(NODE_COUNT);
    localparam int unsigned FREE_W      = $clog2(NODE_COUNT + 1);
    localparam int unsigned SLOT_COUNT  = NODE_COUNT * RADIX;
    localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
    localparam int unsigned KID_IDX_W   = $clog2(RADIX);

    // One word of node information: end mark and one presence bit per child.
    typedef struct packed {
        logic             end_mark;
        logic [RADIX-1:0] kids;
    } t_node_info;

    // Operations of the shared address unit.
    typedef enum logic {
        ALU_SLOT,
        ALU_INC
    } t_alu_op;

endpackage

@@ hdl/dtpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dtpc_ram #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned DATA_W = 8,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hdl/dtpc_alu.sv @@
// Shared address unit: child slot address and free-node increment.
module dtpc_alu (
    input  dtpc_pkg::t_alu_op                  i_op,
    input  logic [dtpc_pkg::NODE_W-1:0]        i_node,
    input  logic [dtpc_pkg::KID_IDX_W-1:0]     i_digit,
    input  logic [dtpc_pkg::FREE_W-1:0]        i_count,
    output logic [dtpc_pkg::SLOT_W-1:0]        o_result
);
    import dtpc_pkg::*;

    // Slot address is node times radix plus digit; the increment bumps the free count.
    always_comb begin
        unique case (i_op)
            ALU_SLOT: o_result = SLOT_W'(i_node) * SLOT_W'(RADIX) + SLOT_W'(i_digit);
            ALU_INC:  o_result = SLOT_W'(i_count) + SLOT_W'(1);
            default:  o_result = '0;
        endcase
    end

endmodule

@@ hdl/digit_trie_prefix_conflict_core.sv @@
// Top level: trie sequencer, node pool memories and result register.
// A walking or growing digit passes read, look, check or alloc, and done; a skipped
// digit goes straight to done, and a pool-full digit goes from look to done.
// Only a final digit strobes, registered after done; no new digit is taken until idle.
// A clear empties the set and rewrites only the root node; reset does not empty it.
// Synchronous active-low reset returns to idle; results cannot stall.
`include "assert_macros.svh"

module digit_trie_prefix_conflict_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [dtpc_pkg::DIGIT_W-1:0]  i_digit,
    input  logic                          i_final_digit,
    output logic                          o_result_strobe,
    output logic                          o_string_conflict,
    output logic                          o_set_conflict,
    output logic                          o_pool_full
);
    import dtpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_LOOK,
        S_ALLOC,
        S_CHECK,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [KID_IDX_W-1:0]  r_digit, n_digit;
    logic                  r_last, n_last;
    logic [NODE_W-1:0]     r_cur, n_cur;
    logic [FREE_W-1:0]     r_next_free, n_next_free;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_string_hit, n_string_hit;
    logic                  r_set_hit, n_set_hit;
    logic                  r_full, n_full;
    logic                  r_drop, n_drop;
    logic                  r_strobe, n_strobe;
    logic                  r_out_string, n_out_string;
    logic                  r_out_set, n_out_set;
    logic                  r_out_full, n_out_full;

    logic                  child_we, child_re;
    logic [SLOT_W-1:0]     child_waddr, child_raddr;
    logic [NODE_W-1:0]     child_wdata, child_rdata;
    logic                  info_we, info_re;
    logic [NODE_W-1:0]     info_waddr, info_raddr;
    t_node_info            info_wdata, info_rdata;

    t_alu_op               alu_op;
    logic [SLOT_W-1:0]     alu_result;
    logic [KID_IDX_W-1:0]  digit_sat;
    logic                  kid_present;

    // Child links, one slot per node and digit.
    dtpc_ram #(
        .DEPTH  (SLOT_COUNT),
        .DATA_W (NODE_W)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_re    (child_re),
        .i_raddr (child_raddr),
        .o_rdata (child_rdata)
    );

    // End mark and child presence bits, one word per node.
    dtpc_ram #(
        .DEPTH  (NODE_COUNT),
        .DATA_W ($bits(t_node_info))
    ) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (info_waddr),
        .i_wdata (info_wdata),
        .i_re    (info_re),
        .i_raddr (info_raddr),
        .o_rdata (info_rdata)
    );

    // Slot addresses while reading, the free-node increment while allocating.
    assign alu_op = (r_state == S_LOOK) ? ALU_INC : ALU_SLOT;

    dtpc_alu u_alu (
        .i_op     (alu_op),
        .i_node   (r_cur),
        .i_digit  (r_digit),
        .i_count  (r_next_free),
        .o_result (alu_result)
    );

    // Digits beyond the radix saturate to the top digit.
    assign digit_sat = ({1'b0, i_digit} >= DIGIT_EXT_W'(RADIX)) ?
                       KID_IDX_W'(RADIX - 1) : i_digit[KID_IDX_W-1:0];

    assign kid_present = info_rdata.kids[r_digit];

    assign busy              = (r_state != S_IDLE);
    assign o_result_strobe   = r_strobe;
    assign o_string_conflict = r_out_string;
    assign o_set_conflict    = r_out_set;
    assign o_pool_full       = r_out_full;

    // Sequencer: next state, trie walk and memory accesses.
    always_comb begin
        n_state      = r_state;
        n_digit      = r_digit;
        n_last       = r_last;
        n_cur        = r_cur;
        n_next_free  = r_next_free;
        n_slot       = r_slot;
        n_string_hit = r_string_hit;
        n_set_hit    = r_set_hit;
        n_full       = r_full;
        n_drop       = r_drop;
        n_strobe     = 1'b0;
        n_out_string = r_out_string;
        n_out_set    = r_out_set;
        n_out_full   = r_out_full;
        child_we     = 1'b0;
        child_re     = 1'b0;
        child_waddr  = r_slot;
        child_raddr  = alu_result;
        child_wdata  = r_next_free[NODE_W-1:0];
        info_we      = 1'b0;
        info_re      = 1'b0;
        info_waddr   = r_cur;
        info_raddr   = r_cur;
        info_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_digit = digit_sat;
                    n_last  = i_final_digit;
                    if (!i_action) begin
                        n_state = S_CLEAR;
                    end else if (r_string_hit || r_drop) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_CLEAR: begin
                // Empty root; every other node is rewritten when it is allocated.
                info_we      = 1'b1;
                info_waddr   = '0;
                info_wdata   = '0;
                n_next_free  = FREE_W'(1);
                n_cur        = '0;
                n_string_hit = 1'b0;
                n_set_hit    = 1'b0;
                n_full       = 1'b0;
                n_drop       = 1'b0;
                n_state      = S_IDLE;
            end
            S_READ: begin
                child_re = 1'b1;
                info_re  = 1'b1;
                n_slot   = alu_result;
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                if (kid_present) begin
                    // Existing child: fetch its information word.
                    n_cur      = child_rdata;
                    info_re    = 1'b1;
                    info_raddr = child_rdata;
                    n_state    = S_CHECK;
                end else if (r_next_free == FREE_W'(NODE_COUNT)) begin
                    n_full  = 1'b1;
                    n_drop  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // Link a fresh node and mark it present in the parent.
                    child_we        = 1'b1;
                    info_we         = 1'b1;
                    info_wdata      = info_rdata;
                    info_wdata.kids = info_rdata.kids | (RADIX'(1) << r_digit);
                    n_next_free     = alu_result[FREE_W-1:0];
                    n_cur           = r_next_free[NODE_W-1:0];
                    n_state         = S_ALLOC;
                end
            end
            S_ALLOC: begin
                // A fresh node has no children; it is an end if the string stops here.
                info_we             = 1'b1;
                info_wdata.end_mark = r_last;
                info_wdata.kids     = '0;
                n_state             = S_DONE;
            end
            S_CHECK: begin
                if (info_rdata.end_mark) begin
                    n_string_hit = 1'b1;
                    n_set_hit    = 1'b1;
                end else if (r_last) begin
                    info_we             = 1'b1;
                    info_wdata          = info_rdata;
                    info_wdata.end_mark = 1'b1;
                    if (|info_rdata.kids) begin
                        n_string_hit = 1'b1;
                        n_set_hit    = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_last) begin
                    n_strobe     = 1'b1;
                    n_out_string = r_string_hit;
                    n_out_set    = r_set_hit;
                    n_out_full   = r_full;
                    n_cur        = '0;
                    n_string_hit = 1'b0;
                    n_drop       = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_next_free  <= FREE_W'(1);
            r_string_hit <= 1'b0;
            r_set_hit    <= 1'b0;
            r_full       <= 1'b0;
            r_drop       <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_next_free  <= n_next_free;
            r_string_hit <= n_string_hit;
            r_set_hit    <= n_set_hit;
            r_full       <= n_full;
            r_drop       <= n_drop;
            r_strobe     <= n_strobe;
        end
        r_digit      <= n_digit;
        r_last       <= n_last;
        r_slot       <= n_slot;
        r_out_string <= n_out_string;
        r_out_set    <= n_out_set;
        r_out_full   <= n_out_full;
    end

    // A finished string in the done state gives exactly one result transfer.
    `DTPC_ASSERT_NEXT(a_done_strobes, i_clk, i_rst_n, (r_state == S_DONE) && r_last, r_strobe)
    // A string conflict always shows in the sticky set flag.
    `DTPC_ASSERT_SAME(a_hit_sticky, i_clk, i_rst_n, r_string_hit, r_set_hit)
    // Results appear only while the sequencer is back at idle.
    `DTPC_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_state == S_IDLE)
    // Every allocation advances the free pointer by one.
    `DTPC_ASSERT_NEXT(a_alloc_bump, i_clk, i_rst_n, (r_state == S_LOOK) && child_we, r_next_free == FREE_W'($past(r_next_free) + 1'b1))

endmodule
